### sv/fbfcrc8_pkg.sv
// Package for the firmware block framer: frame constants, request codes,
// queue sizing, the result entry type and the CRC-8 (poly 0x07) byte step.
// No dependencies.
package fbfcrc8_pkg;

    // request codes carried in the input tuser
    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_REPLY = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // frame bytes
    localparam logic [7:0] HDR_BYTE   = 8'hAF;
    localparam logic [7:0] TYPE_FIRST = 8'h03;
    localparam logic [7:0] TYPE_NEXT  = 8'h04;
    localparam logic [7:0] TYPE_END   = 8'h06;
    localparam logic [7:0] TYPE_REPLY = 8'h07;
    localparam logic [7:0] END_LEN    = 8'h02;
    localparam logic [7:0] END_CRC    = 8'h12;
    localparam logic [7:0] MIN_LEN    = 8'h02;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam int MAX_BLOCK_DEF = 64;

    // results per request and output queue
    localparam int MAX_RES    = 5;
    localparam int RES_CW     = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    typedef struct packed {
        logic       kind;   // 0 byte to send, 1 reply verdict
        logic [7:0] data;
        logic       ok;
        logic       last;
    } t_res;

    // one CRC-8 byte step, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] c;
        c = crc ^ din;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC state after the type byte of a data block
    localparam logic [7:0] CRC_AFTER_FIRST = crc8_byte(8'h00, TYPE_FIRST);
    localparam logic [7:0] CRC_AFTER_NEXT  = crc8_byte(8'h00, TYPE_NEXT);

endpackage

### sv/firmware_block_framer_crc8.sv
// Firmware block framer and bootloader reply checker, CRC-8 poly 0x07 init 0.
// Depends on fbfcrc8_pkg (constants, result type, CRC byte step).
//
//  channel | dir | tdata (low bit up)                 | tuser                    | tlast
//  --------+-----+------------------------------------+--------------------------+----------
//  s       | in  | data_byte[7:0], block_len[14:8]    | req_type[1:0], first[2]  | -
//  m       | out | out_byte[7:0], reply_ok[8]         | out_kind                 | frame_end
//
//  A request producing one result can be taken every cycle while the output queue has room;
//  one producing n results holds the slave side until its results have entered the output queue, one per cycle
//  through its single write port while the queue has room. Requests with no result never hold the slave side.
//  The first result of a request passes through the pending list, the queue memory and the
//  read register, in that order, before it is offered on the master side.
//  Reset (i_rst_n low, synchronous) clears framer/checker state and empties the queue.
//  A stalled master side fills the 8-entry queue, then backs up into the slave side.
module firmware_block_framer_crc8 #(
    parameter int MAX_BLOCK = fbfcrc8_pkg::MAX_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // data_byte[7:0], block_len[14:8], zero[15]
    input  logic [2:0]  i_s_tuser,   // req_type[1:0], first_block[2]
    // result side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // out_byte[7:0], reply_ok[8], zero[15:9]
    output logic        o_m_tuser,   // out_kind
    output logic        o_m_tlast    // frame_end
);

    localparam logic [7:0] MaxBlk = 8'(MAX_BLOCK);
    localparam int         AW     = fbfcrc8_pkg::FIFO_AW;
    localparam logic [AW:0] FullCnt = (AW+1)'(fbfcrc8_pkg::FIFO_DEPTH);
    localparam int         RCW    = fbfcrc8_pkg::RES_CW;
    localparam int         NRES   = fbfcrc8_pkg::MAX_RES;

    // request fields
    logic [1:0] req;
    logic [7:0] din;
    logic       first;
    logic [6:0] blen;

    assign req   = i_s_tuser[1:0];
    assign first = i_s_tuser[2];
    assign din   = i_s_tdata[7:0];
    assign blen  = i_s_tdata[14:8];

    // framer / checker state
    logic [6:0] r_tx_count, n_tx_count;
    logic [7:0] r_tx_crc,   n_tx_crc;
    logic [8:0] r_rx_count, n_rx_count;
    logic [7:0] r_rx_len,   n_rx_len;
    logic [7:0] r_rx_crc,   n_rx_crc;
    logic       r_rx_type_ok, n_rx_type_ok;

    // pending results of the last accepted request, drained from index 0
    fbfcrc8_pkg::t_res r_pend [NRES];
    fbfcrc8_pkg::t_res n_list [NRES];
    logic [RCW-1:0]    r_pend_cnt;
    logic [RCW-1:0]    n_k;

    // output queue: memory with registered read, read register feeds the port
    fbfcrc8_pkg::t_res mem [fbfcrc8_pkg::FIFO_DEPTH];
    fbfcrc8_pkg::t_res r_rd_data;
    logic              r_rd_vld;
    logic [AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [AW:0]       r_fcnt;

    logic       acc, push, rd;
    logic [7:0] eff, crc_base, crc_new, cnt_inc;
    logic       closes;
    logic [8:0] rx_end;

    assign push       = (r_pend_cnt != '0) && (r_fcnt != FullCnt);
    assign o_s_tready = (r_pend_cnt == '0) || ((r_pend_cnt == RCW'(1)) && push);
    assign acc        = i_s_tvalid && o_s_tready;
    assign rd         = (r_fcnt != '0) && (!r_rd_vld || i_m_tready);

    // block length clamp and CRC for a data byte
    always_comb begin
        if (blen == 7'd0) begin
            eff = 8'd1;
        end else if ({1'b0, blen} > MaxBlk) begin
            eff = MaxBlk;
        end else begin
            eff = {1'b0, blen};
        end
        if (r_tx_count == 7'd0) begin
            crc_base = first ? fbfcrc8_pkg::CRC_AFTER_FIRST : fbfcrc8_pkg::CRC_AFTER_NEXT;
        end else begin
            crc_base = r_tx_crc;
        end
        crc_new = fbfcrc8_pkg::crc8_byte(crc_base, din);
        cnt_inc = {1'b0, r_tx_count} + 8'd1;
        closes  = (cnt_inc >= eff);
        rx_end  = {1'b0, r_rx_len} + 9'd1;
    end

    // result list and next state for one request
    always_comb begin
        n_tx_count   = r_tx_count;
        n_tx_crc     = r_tx_crc;
        n_rx_count   = r_rx_count;
        n_rx_len     = r_rx_len;
        n_rx_crc     = r_rx_crc;
        n_rx_type_ok = r_rx_type_ok;
        n_k          = '0;
        for (int i = 0; i < NRES; i++) begin
            n_list[i] = '0;
        end
        case (req)
            fbfcrc8_pkg::REQ_DATA: begin
                if (r_tx_count == 7'd0) begin
                    // new block: header, len, type ahead of the byte
                    n_list[0].data = fbfcrc8_pkg::HDR_BYTE;
                    n_list[1].data = eff + 8'd2;
                    n_list[2].data = first ? fbfcrc8_pkg::TYPE_FIRST
                                           : fbfcrc8_pkg::TYPE_NEXT;
                    n_list[3].data = din;
                    n_list[4].data = crc_new;
                    n_list[4].last = 1'b1;
                    n_k = closes ? RCW'(5) : RCW'(4);
                end else begin
                    n_list[0].data = din;
                    n_list[1].data = crc_new;
                    n_list[1].last = 1'b1;
                    n_k = closes ? RCW'(2) : RCW'(1);
                end
                n_tx_count = closes ? 7'd0 : cnt_inc[6:0];
                n_tx_crc   = closes ? 8'd0 : crc_new;
            end
            fbfcrc8_pkg::REQ_END: begin
                // an open block is dropped without its CRC
                n_tx_count     = 7'd0;
                n_tx_crc       = 8'd0;
                n_list[0].data = fbfcrc8_pkg::HDR_BYTE;
                n_list[1].data = fbfcrc8_pkg::END_LEN;
                n_list[2].data = fbfcrc8_pkg::TYPE_END;
                n_list[3].data = fbfcrc8_pkg::END_CRC;
                n_list[3].last = 1'b1;
                n_k = RCW'(4);
            end
            fbfcrc8_pkg::REQ_REPLY: begin
                n_list[0].kind = 1'b1;
                n_list[0].last = 1'b1;
                if (r_rx_count == 9'd0) begin
                    if (din != fbfcrc8_pkg::HDR_BYTE) begin
                        n_k = RCW'(1);
                    end else begin
                        n_rx_count = 9'd1;
                    end
                end else if (r_rx_count == 9'd1) begin
                    if (din < fbfcrc8_pkg::MIN_LEN) begin
                        n_k        = RCW'(1);
                        n_rx_count = 9'd0;
                    end else begin
                        n_rx_len     = din;
                        n_rx_crc     = 8'd0;
                        n_rx_type_ok = 1'b0;
                        n_rx_count   = 9'd2;
                    end
                end else if (r_rx_count >= rx_end) begin
                    // CRC byte: give the verdict
                    n_list[0].ok = r_rx_type_ok && (din == r_rx_crc);
                    n_k          = RCW'(1);
                    n_rx_count   = 9'd0;
                end else begin
                    if (r_rx_count == 9'd2) begin
                        n_rx_type_ok = (din == fbfcrc8_pkg::TYPE_REPLY);
                    end
                    n_rx_crc   = fbfcrc8_pkg::crc8_byte(r_rx_crc, din);
                    n_rx_count = r_rx_count + 9'd1;
                end
            end
            default: begin
                // unused code: no results, no state change
            end
        endcase
    end

    // state and pending results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_count   <= '0;
            r_tx_crc     <= '0;
            r_rx_count   <= '0;
            r_rx_len     <= '0;
            r_rx_crc     <= '0;
            r_rx_type_ok <= 1'b0;
            r_pend_cnt   <= '0;
        end else begin
            if (acc) begin
                r_tx_count   <= n_tx_count;
                r_tx_crc     <= n_tx_crc;
                r_rx_count   <= n_rx_count;
                r_rx_len     <= n_rx_len;
                r_rx_crc     <= n_rx_crc;
                r_rx_type_ok <= n_rx_type_ok;
                r_pend_cnt   <= n_k;
            end else if (push) begin
                r_pend_cnt <= r_pend_cnt - RCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && (n_k != '0)) begin
            r_pend <= n_list;
        end else if (push) begin
            for (int i = 0; i < NRES - 1; i++) begin
                r_pend[i] <= r_pend[i + 1];
            end
        end
    end

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({push, rd})
                2'b10:   r_fcnt <= r_fcnt + (AW+1)'(1);
                2'b01:   r_fcnt <= r_fcnt - (AW+1)'(1);
                default: r_fcnt <= r_fcnt;
            endcase
            r_rd_vld <= rd || (r_rd_vld && !i_m_tready);
        end
    end

    // queue memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[r_wr_ptr] <= r_pend[0];
        end
        if (rd) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    assign o_m_tvalid = r_rd_vld;
    assign o_m_tdata  = {7'd0, r_rd_data.ok, r_rd_data.data};
    assign o_m_tuser  = r_rd_data.kind;
    assign o_m_tlast  = r_rd_data.last;

    // checks
    a_fcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FullCnt)
        else $error("output queue count past depth");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= RCW'(NRES))
        else $error("pending result count past maximum");

    a_verdict_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && (o_m_tdata[7:0] == 8'd0)))
        else $error("verdict result not zero byte with frame end");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_m_tvalid && (r_fcnt == '0)))
        else $error("results present after reset");

endmodule

### tb/sv/tb_firmware_block_framer_crc8.sv
`timescale 1ns / 1ps
// Self-checking bench for firmware_block_framer_crc8: directed and random requests,
// with a request-level model of the framer and reply checker that scores every result.
// Depends on fbfcrc8_pkg and the firmware_block_framer_crc8 RTL.
module tb_firmware_block_framer_crc8;

    localparam int BLOCK_MAX      = fbfcrc8_pkg::MAX_BLOCK_DEF;
    localparam int ITEMS          = 380;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_CAP     = 100;

    typedef struct {
        logic [1:0] req;
        logic [7:0] data;
        logic       first;
        logic [6:0] blen;
    } t_link_req;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       ok;
        logic       last;
    } t_link_out;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;
    logic [2:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    firmware_block_framer_crc8 #(
        .MAX_BLOCK (BLOCK_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_link_req req_q[$];    // requests waiting to be driven
    t_link_out link_q[$];   // frame bytes and verdicts still owed by the block

    int n_total      = 0;   // requests queued
    int n_live       = 0;   // requests that are not the unused code
    int n_taken      = 0;   // requests accepted by the block
    int n_err        = 0;
    int stall_cycles = 0;

    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    int   s_gap   = 0;
    int   m_wait  = 0;
    bit   s_calm  = 1'b0;
    bit   m_calm  = 1'b0;

    // model state
    logic [6:0] tx_cnt     = '0;
    logic [7:0] tx_crc     = '0;
    logic [8:0] rx_cnt     = '0;
    logic [7:0] rx_len     = '0;
    logic [7:0] rx_crc     = '0;
    logic       rx_type_ok = 1'b0;

    // CRC-8, poly 0x07, MSB first
    function automatic logic [7:0] crc8_p07(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic int draw_wait(input bit calm);
        if (calm) return 0;
        return int'($urandom_range(0, 17));
    endfunction

    task automatic add_out(input logic kind, input logic [7:0] b, input logic ok,
                           input logic last);
        t_link_out o;
        o.kind = kind;
        o.data = b;
        o.ok   = ok;
        o.last = last;
        link_q.push_back(o);
    endtask

    // expected results of one accepted request
    task automatic predict_link(input logic [1:0] req, input logic [7:0] b,
                                input logic first, input logic [6:0] blen);
        int         eff;
        logic [7:0] typ;
        logic [7:0] lenb;
        logic       ok;
        case (req)
            fbfcrc8_pkg::REQ_DATA: begin
                eff = (blen == 7'd0) ? 1 : (blen > BLOCK_MAX) ? BLOCK_MAX : int'(blen);
                if (tx_cnt == 7'd0) begin
                    typ  = first ? fbfcrc8_pkg::TYPE_FIRST : fbfcrc8_pkg::TYPE_NEXT;
                    lenb = 8'(eff + 2);
                    add_out(1'b0, fbfcrc8_pkg::HDR_BYTE, 1'b0, 1'b0);
                    add_out(1'b0, lenb, 1'b0, 1'b0);
                    add_out(1'b0, typ, 1'b0, 1'b0);
                    tx_crc = crc8_p07(8'h00, typ);
                end
                tx_crc = crc8_p07(tx_crc, b);
                tx_cnt = tx_cnt + 7'd1;
                add_out(1'b0, b, 1'b0, 1'b0);
                // block closes once the count meets the length given now
                if (tx_cnt >= eff) begin
                    add_out(1'b0, tx_crc, 1'b0, 1'b1);
                    tx_cnt = '0;
                    tx_crc = '0;
                end
            end
            fbfcrc8_pkg::REQ_END: begin
                // an open block is dropped without its CRC
                tx_cnt = '0;
                tx_crc = '0;
                add_out(1'b0, fbfcrc8_pkg::HDR_BYTE, 1'b0, 1'b0);
                add_out(1'b0, fbfcrc8_pkg::END_LEN, 1'b0, 1'b0);
                add_out(1'b0, fbfcrc8_pkg::TYPE_END, 1'b0, 1'b0);
                add_out(1'b0, fbfcrc8_pkg::END_CRC, 1'b0, 1'b1);
            end
            fbfcrc8_pkg::REQ_REPLY: begin
                if (rx_cnt == 9'd0) begin
                    if (b != fbfcrc8_pkg::HDR_BYTE) add_out(1'b1, 8'h00, 1'b0, 1'b1);
                    else rx_cnt = 9'd1;
                end else if (rx_cnt == 9'd1) begin
                    if (b < fbfcrc8_pkg::MIN_LEN) begin
                        add_out(1'b1, 8'h00, 1'b0, 1'b1);
                        rx_cnt = 9'd0;
                    end else begin
                        rx_len     = b;
                        rx_crc     = '0;
                        rx_type_ok = 1'b0;
                        rx_cnt     = 9'd2;
                    end
                end else if (rx_cnt >= rx_len + 9'd1) begin
                    ok = rx_type_ok && (b == rx_crc);
                    add_out(1'b1, 8'h00, ok, 1'b1);
                    rx_cnt = 9'd0;
                end else begin
                    if (rx_cnt == 9'd2) rx_type_ok = (b == fbfcrc8_pkg::TYPE_REPLY);
                    rx_crc = crc8_p07(rx_crc, b);
                    rx_cnt = rx_cnt + 9'd1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            n_err++;
            if (n_err <= REPORT_CAP) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // ---- stimulus builders ----

    task automatic add_req(input logic [1:0] req, input logic [7:0] b, input logic first,
                           input logic [6:0] blen);
        t_link_req r;
        r.req   = req;
        r.data  = b;
        r.first = first;
        r.blen  = blen;
        req_q.push_back(r);
        n_total++;
        if (req != fbfcrc8_pkg::REQ_NONE) n_live++;
    endtask

    // first_block and block_len carry noise where they do not matter
    task automatic add_misc(input logic [1:0] req, input logic [7:0] b);
        add_req(req, b, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
    endtask

    // one firmware block; sometimes cut short by an end command or a length change
    task automatic add_block(input logic first, input int len);
        int         mode;
        int         cut;
        logic [6:0] field;
        mode = int'($urandom_range(0, 9));
        cut  = (len > 1) ? int'($urandom_range(1, len - 1)) : len;
        if (len >= BLOCK_MAX) field = 7'($urandom_range(BLOCK_MAX, 127));
        else if (len == 1 && $urandom_range(0, 3) == 0) field = 7'd0;
        else field = 7'(len);
        for (int i = 0; i < len; i++) begin
            if (mode == 0 && i == cut) begin
                add_misc(fbfcrc8_pkg::REQ_END, 8'($urandom));
                return;
            end
            if (mode == 1 && i == cut) field = 7'($urandom_range(1, len));
            add_req(fbfcrc8_pkg::REQ_DATA, 8'($urandom), first, field);
        end
    endtask

    // reply frame: header, len, type, len-2 payload bytes, CRC
    task automatic add_reply(input logic [7:0] len, input logic [7:0] typ, input bit spoil);
        logic [7:0] crc;
        logic [7:0] b;
        add_misc(fbfcrc8_pkg::REQ_REPLY, fbfcrc8_pkg::HDR_BYTE);
        add_misc(fbfcrc8_pkg::REQ_REPLY, len);
        add_misc(fbfcrc8_pkg::REQ_REPLY, typ);
        crc = crc8_p07(8'h00, typ);
        for (int i = 2; i < len; i++) begin
            b = 8'($urandom);
            add_misc(fbfcrc8_pkg::REQ_REPLY, b);
            crc = crc8_p07(crc, b);
        end
        add_misc(fbfcrc8_pkg::REQ_REPLY, spoil ? ~crc : crc);
    endtask

    // ---- request driver: changes on the falling edge ----
    always @(negedge i_clk) begin : req_driver
        t_link_req nxt;
        if (i_rst_n && !(i_s_tvalid && !s_taken)) begin
            if (i_s_tvalid) begin
                // last request went in; pick the pause before the next one
                if ($urandom_range(0, 23) == 0) s_calm = !s_calm;
                s_gap = draw_wait(s_calm);
            end
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (req_q.size() != 0) begin
                nxt = req_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {1'b0, nxt.blen, nxt.data};
                i_s_tuser  <= {nxt.first, nxt.req};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ---- result-side back-pressure ----
    always @(negedge i_clk) begin : res_ready
        if (i_rst_n) begin
            if (m_taken) begin
                if ($urandom_range(0, 23) == 0) m_calm = !m_calm;
                m_wait = draw_wait(m_calm);
            end
            if (m_wait > 0) begin
                m_wait = m_wait - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ---- monitor: both handshakes sampled on the rising edge ----
    always @(posedge i_clk) begin : link_monitor
        t_link_out want;
        logic      s_fire;
        logic      m_fire;
        if (!i_rst_n) begin
            s_taken      <= 1'b0;
            m_taken      <= 1'b0;
            stall_cycles <= 0;
        end else begin
            s_fire = i_s_tvalid && o_s_tready;
            m_fire = o_m_tvalid && i_m_tready;
            s_taken <= s_fire;
            m_taken <= m_fire;
            if (m_fire) begin
                if (link_q.size() == 0) begin
                    n_err++;
                    if (n_err <= REPORT_CAP)
                        $error("result with none owed: kind %0d byte 0x%0h ok %0d end %0d",
                               o_m_tuser, o_m_tdata[7:0], o_m_tdata[8], o_m_tlast);
                end else begin
                    want = link_q.pop_front();
                    check_field("out_kind", want.kind, o_m_tuser);
                    check_field("out_byte", want.data, o_m_tdata[7:0]);
                    check_field("reply_ok", want.ok, o_m_tdata[8]);
                    check_field("frame_end", want.last, o_m_tlast);
                end
            end
            if (s_fire) begin
                predict_link(i_s_tuser[1:0], i_s_tdata[7:0], i_s_tuser[2], i_s_tdata[14:8]);
                n_taken++;
            end
            stall_cycles <= (s_fire || m_fire) ? 0 : stall_cycles + 1;
        end
    end

    // ---- stimulus, reset and end of run ----
    initial begin : run
        int         pick;
        bit         long_done;
        logic [7:0] b;

        // directed: shortest block, zero and oversized lengths, length change,
        // end inside a block, unused code, good and failing replies
        add_req(fbfcrc8_pkg::REQ_DATA, 8'h00, 1'b1, 7'd1);
        add_req(fbfcrc8_pkg::REQ_DATA, 8'hFF, 1'b0, 7'd0);
        add_req(fbfcrc8_pkg::REQ_DATA, 8'h5A, 1'b1, 7'd127);
        add_req(fbfcrc8_pkg::REQ_DATA, 8'hA5, 1'b1, 7'd2);
        add_req(fbfcrc8_pkg::REQ_DATA, 8'h81, 1'b0, 7'd3);
        add_req(fbfcrc8_pkg::REQ_END, 8'hFF, 1'b1, 7'd127);
        add_req(fbfcrc8_pkg::REQ_NONE, 8'hFF, 1'b1, 7'd127);
        add_reply(8'd2, fbfcrc8_pkg::TYPE_REPLY, 1'b0);
        add_misc(fbfcrc8_pkg::REQ_REPLY, 8'h00);                 // bad header
        add_misc(fbfcrc8_pkg::REQ_REPLY, fbfcrc8_pkg::HDR_BYTE); // len below two
        add_misc(fbfcrc8_pkg::REQ_REPLY, 8'h01);
        add_reply(8'd3, 8'h05, 1'b0);                            // wrong type
        add_reply(8'd2, fbfcrc8_pkg::TYPE_REPLY, 1'b1);          // wrong CRC

        // random: mostly whole blocks and replies, some noise
        long_done = 1'b0;
        while (n_live < ITEMS) begin
            pick = int'($urandom_range(0, 99));
            if (!long_done && n_live > 150) begin
                long_done = 1'b1;
                add_reply(8'($urandom_range(128, 200)), fbfcrc8_pkg::TYPE_REPLY, 1'b0);
            end else if (pick < 45) begin
                add_block(1'($urandom_range(0, 1)),
                          ($urandom_range(0, 14) == 0) ? BLOCK_MAX
                                                       : int'($urandom_range(1, 8)));
            end else if (pick < 53) begin
                add_misc(fbfcrc8_pkg::REQ_END, 8'($urandom));
            end else if (pick < 83) begin
                add_reply(8'($urandom_range(2, 12)),
                          ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                      : fbfcrc8_pkg::TYPE_REPLY,
                          $urandom_range(0, 4) == 0);
            end else if (pick < 93) begin
                case ($urandom_range(0, 2))
                    0: begin
                        b = 8'($urandom);
                        if (b == fbfcrc8_pkg::HDR_BYTE) b = 8'h00;
                        add_misc(fbfcrc8_pkg::REQ_REPLY, b);
                    end
                    1: begin
                        add_misc(fbfcrc8_pkg::REQ_REPLY, fbfcrc8_pkg::HDR_BYTE);
                        add_misc(fbfcrc8_pkg::REQ_REPLY, 8'($urandom_range(0, 1)));
                    end
                    default: repeat ($urandom_range(1, 3))
                        add_misc(fbfcrc8_pkg::REQ_REPLY, 8'($urandom));
                endcase
            end else begin
                add_misc(fbfcrc8_pkg::REQ_NONE, 8'($urandom));
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin : drain
                do @(negedge i_clk); while (n_taken != n_total || link_q.size() != 0);
                repeat (DRAIN_CYCLES) @(negedge i_clk);
            end
            begin : watchdog
                wait (stall_cycles >= WATCHDOG_LIMIT);
            end
        join_any

        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_firmware_block_framer_crc8: done, errors");
        end else if (n_err == 0) begin
            $display("tb_firmware_block_framer_crc8: done, clean");
        end else begin
            $display("tb_firmware_block_framer_crc8: done, errors");
        end
        $finish;
    end

endmodule
